### rtl/core/ldcd_pkg.sv
// Shared types, constants and a mod-10 helper for the Luhn / DEA check-digit validator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ldcd_pkg;

    // Value of the check_mode register.
    localparam logic C_MODE_LUHN = 1'b0;
    localparam logic C_MODE_DEA  = 1'b1;

    localparam logic [7:0] C_ASCII_ZERO = 8'h30;
    localparam logic [7:0] C_ASCII_NINE = 8'h39;

    localparam logic [4:0] C_RADIX      = 5'd10;
    localparam logic [4:0] C_LUHN_FOLD  = 5'd9;

    typedef logic [3:0] t_dec;

    // One decoded character.
    typedef struct packed {
        logic is_digit;
        t_dec value;
        t_dec doubled;
    } t_digit;

    // Verdict handed from the accumulator to the output register.
    typedef struct packed {
        logic check_passed;
        logic no_digits;
    } t_verdict;

    // Sum of two decimal digits, reduced mod 10.
    function automatic t_dec mod10_add(input t_dec a, input t_dec b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= C_RADIX) begin
            s = s - C_RADIX;
        end
        return s[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/ldcd_digit.sv
// Character decoder: recognizes ASCII digits and forms the weight-2 term for the active mode.
// Depends on ldcd_pkg.
`default_nettype none

module ldcd_digit (
    input  wire logic [7:0]      i_char,
    input  wire logic            i_mode,
    output ldcd_pkg::t_digit     o_digit
);
    import ldcd_pkg::*;

    logic [3:0] w_val;
    logic [4:0] w_dbl;

    always_comb begin
        // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value.
        w_val = i_char[3:0];
        w_dbl = {w_val, 1'b0};
        // Luhn folds a doubled digit above nine back into a single digit.
        if (i_mode == C_MODE_LUHN && w_dbl > C_LUHN_FOLD) begin
            w_dbl = w_dbl - C_LUHN_FOLD;
        end else if (i_mode == C_MODE_DEA && w_dbl >= C_RADIX) begin
            w_dbl = w_dbl - C_RADIX;
        end
        o_digit.is_digit = (i_char >= C_ASCII_ZERO) && (i_char <= C_ASCII_NINE);
        o_digit.value    = w_val;
        o_digit.doubled  = w_dbl[3:0];
    end

endmodule

`default_nettype wire

### rtl/core/ldcd_accum.sv
// Running mod-10 sums for both doubling parities, plus the end-of-string verdict.
// Depends on ldcd_pkg.
`default_nettype none

module ldcd_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_last,
    input  wire logic             i_mode,
    input  wire ldcd_pkg::t_digit i_digit,
    output ldcd_pkg::t_verdict    o_verdict
);
    import ldcd_pkg::*;

    t_dec r_sum_even, n_sum_even;
    t_dec r_sum_odd,  n_sum_odd;
    logic r_parity,   n_parity;
    t_dec r_last,     n_last;
    logic r_seen,     n_seen;

    t_dec w_sel;
    t_dec w_adj;

    always_comb begin
        n_sum_even = r_sum_even;
        n_sum_odd  = r_sum_odd;
        n_parity   = r_parity;
        n_last     = r_last;
        n_seen     = r_seen;
        if (i_digit.is_digit) begin
            if (!r_parity) begin
                n_sum_even = mod10_add(r_sum_even, i_digit.doubled);
                n_sum_odd  = mod10_add(r_sum_odd,  i_digit.value);
            end else begin
                n_sum_even = mod10_add(r_sum_even, i_digit.value);
                n_sum_odd  = mod10_add(r_sum_odd,  i_digit.doubled);
            end
            n_parity = ~r_parity;
            n_last   = i_digit.value;
            n_seen   = 1'b1;
        end
    end

    // The verdict looks at the state including the current character.
    always_comb begin
        w_sel = n_parity ? n_sum_odd : n_sum_even;
        // The last digit went in with weight one but needs minus one.
        w_adj = mod10_add(n_last, n_last);
        if (!n_seen) begin
            o_verdict.check_passed = (i_mode == C_MODE_LUHN);
        end else if (i_mode == C_MODE_LUHN) begin
            o_verdict.check_passed = (w_sel == '0);
        end else begin
            o_verdict.check_passed = (w_sel == w_adj);
        end
        o_verdict.no_digits = ~n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_even <= '0;
            r_sum_odd  <= '0;
            r_parity   <= 1'b0;
            r_last     <= '0;
            r_seen     <= 1'b0;
        end else if (i_advance) begin
            if (i_last) begin
                r_sum_even <= '0;
                r_sum_odd  <= '0;
                r_parity   <= 1'b0;
                r_last     <= '0;
                r_seen     <= 1'b0;
            end else begin
                r_sum_even <= n_sum_even;
                r_sum_odd  <= n_sum_odd;
                r_parity   <= n_parity;
                r_last     <= n_last;
                r_seen     <= n_seen;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/luhn_and_dea_check_digit_validator.sv
// Top level of the streaming Luhn / DEA check-digit validator.
// Depends on ldcd_pkg, ldcd_digit and ldcd_accum.
`default_nettype none

//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_char_in[7:0], i_end_of_string
//  out     | source    | o_out_valid/ i_out_stall| o_check_passed, o_no_digits
//  cfg     | sink      | i_cfg_valid/ o_cfg_ready| i_cfg_data (check_mode)
//
// One character is accepted every cycle unless a string-ending character waits
// for a stalled result. A character sits in the input register, where the
// decoder and the accumulator update consume it; a character that ends its
// string loads the verdict into the output register, which shows it in the
// next cycle. Each character takes a single accumulator update, and a verdict
// passes the input and output registers in turn. Reset (synchronous, active
// low) clears all sums, the mode register and both valid flags. A stalled
// result only holds back a string-ending character; characters that produce
// no result keep flowing into the accumulator.

module luhn_and_dea_check_digit_validator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Character stream.
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_end_of_string,
    // Verdicts.
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_check_passed,
    output logic            o_no_digits,
    // Mode register write.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data
);
    import ldcd_pkg::*;

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_eos;

    // Configuration register.
    logic       r_mode;

    // Output register.
    logic       r_out_vld;
    t_verdict   r_out;

    t_digit     w_digit;
    t_verdict   w_verdict;
    logic       w_out_free;
    logic       w_advance;
    logic       w_in_take;

    // The output slot is free when empty or when its transaction completes now.
    assign w_out_free = ~r_out_vld | ~i_out_stall;
    // A held character moves on unless it must produce a verdict and the slot is busy.
    assign w_advance  = r_in_vld & (~r_in_eos | w_out_free);
    assign o_in_stall = r_in_vld & ~w_advance;
    assign w_in_take  = i_in_valid & ~o_in_stall;

    assign o_cfg_ready = 1'b1;

    ldcd_digit u_digit (
        .i_char  (r_in_char),
        .i_mode  (r_mode),
        .o_digit (w_digit)
    );

    ldcd_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_last    (r_in_eos),
        .i_mode    (r_mode),
        .i_digit   (w_digit),
        .o_verdict (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= C_MODE_LUHN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_char_in;
            r_in_eos  <= i_end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance && r_in_eos) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_eos) begin
            r_out <= w_verdict;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_check_passed = r_out.check_passed;
    assign o_no_digits    = r_out.no_digits;

endmodule

`default_nettype wire
